### src/key_press_classifier_macros.svh
// Assertion macros shared by the key press classifier checker.
`ifndef KEY_PRESS_CLASSIFIER_MACROS_SVH
`define KEY_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, reported with $error.
`define KPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reported with $error.
`define KPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/kpc_pkg.sv
// Package with register map and threshold constants of the key press classifier.
package kpc_pkg;

  localparam int THR_WIDTH = 16;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int REG_IDX_WIDTH = APB_ADDR_WIDTH - 2;

  localparam logic [THR_WIDTH-1:0] PRESS_RESET = 16'd100;
  localparam logic [THR_WIDTH-1:0] LONG_RESET = 16'd1000;

  localparam logic [REG_IDX_WIDTH-1:0] REG_PRESS = 1'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_LONG = 1'd1;

endpackage

### src/key_press_classifier.sv
// Top level of the key press classifier: hold counters and per-key flags.
// An accepted item passes the input register and then the result register.
// Throughput: one item per cycle while results are taken; the counter update and flag compares fit one stage.
// The input register stalls only while a waiting result sees m_tready low.
// Synchronous reset clears the counters, phases, valid flags and restores thresholds.
module key_press_classifier
  import kpc_pkg::*;
#(
  parameter int NUM_KEYS = 9,
  parameter int COUNT_WIDTH = 16,
  parameter int REPEAT_PERIOD = 500
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: key_levels
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((NUM_KEYS+7)/8)*8-1:0]     s_tdata,
  // m_tdata: held_mask, long_mask, once_mask, repeat_mask
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [((4*NUM_KEYS+7)/8)*8-1:0]   m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [APB_ADDR_WIDTH-1:0]         paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int OUT_W = ((4*NUM_KEYS+7)/8)*8;
  localparam int CMP_W = ((COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH) + 1;
  localparam int PH_W = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(REPEAT_PERIOD - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [THR_WIDTH-1:0]   press_threshold;
  logic [THR_WIDTH-1:0]   long_threshold;
  logic [REG_IDX_WIDTH-1:0] reg_idx;
  logic                   cfg_write;

  logic                   in_valid;
  logic [NUM_KEYS-1:0]    key_levels;
  logic                   advance;

  logic [COUNT_WIDTH-1:0] hold_count [NUM_KEYS];
  logic [COUNT_WIDTH-1:0] hold_count_next [NUM_KEYS];
  logic [PH_W-1:0]        phase [NUM_KEYS];
  logic [PH_W-1:0]        phase_next [NUM_KEYS];

  logic [NUM_KEYS-1:0]    held_next, long_next, once_next, repeat_next;
  logic [NUM_KEYS-1:0]    held_mask, long_mask, once_mask, repeat_mask;
  logic [CMP_W-1:0]       press1, long1;

  assign pready = 1'b1;
  assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_PRESS: prdata = 32'(press_threshold);
      REG_LONG:  prdata = 32'(long_threshold);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold <= PRESS_RESET;
      long_threshold <= LONG_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_PRESS: press_threshold <= pwdata[THR_WIDTH-1:0];
        REG_LONG:  long_threshold <= pwdata[THR_WIDTH-1:0];
        default:   ;
      endcase
    end
  end

  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      key_levels <= s_tdata[NUM_KEYS-1:0];
    end
  end

  assign press1 = CMP_W'(press_threshold) + CMP_W'(1);
  assign long1 = CMP_W'(long_threshold) + CMP_W'(1);

  always_comb begin
    logic           adv;
    logic [CMP_W-1:0] c;
    for (int k = 0; k < NUM_KEYS; k++) begin
      adv = 1'b0;
      if (!key_levels[k]) begin
        hold_count_next[k] = '0;
        phase_next[k] = '0;
      end else if (hold_count[k] != CNT_MAX) begin
        hold_count_next[k] = hold_count[k] + COUNT_WIDTH'(1);
        phase_next[k] = (phase[k] == PH_LAST) ? '0 : phase[k] + PH_W'(1);
        adv = 1'b1;
      end else begin
        hold_count_next[k] = hold_count[k];
        phase_next[k] = phase[k];
      end
      c = CMP_W'(hold_count_next[k]);
      held_next[k] = c > CMP_W'(press_threshold);
      long_next[k] = c > CMP_W'(long_threshold);
      once_next[k] = adv && (c == press1);
      repeat_next[k] = adv && ((c == long1) || ((c > long1) && (phase_next[k] == '0)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_count[k] <= '0;
        phase[k] <= '0;
      end
    end else if (advance) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_count[k] <= hold_count_next[k];
        phase[k] <= phase_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_mask <= held_next;
      long_mask <= long_next;
      once_mask <= once_next;
      repeat_mask <= repeat_next;
    end
  end

  assign m_tdata = OUT_W'({repeat_mask, once_mask, long_mask, held_mask});

endmodule

### src/kpc_checker.sv
// Port-level checker for the key press classifier and its bind statement.
`include "key_press_classifier_macros.svh"

module kpc_checker #(
  parameter int NUM_KEYS = 9
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [((4*NUM_KEYS+7)/8)*8-1:0] m_tdata
);

  logic [NUM_KEYS-1:0] held_mask, long_mask, once_mask, repeat_mask;

  assign held_mask = m_tdata[NUM_KEYS-1:0];
  assign long_mask = m_tdata[2*NUM_KEYS-1:NUM_KEYS];
  assign once_mask = m_tdata[3*NUM_KEYS-1:2*NUM_KEYS];
  assign repeat_mask = m_tdata[4*NUM_KEYS-1:3*NUM_KEYS];

  `KPC_ASSERT_SAME(a_once_held, clk, rst, m_tvalid, (once_mask & ~held_mask) == '0, "once without held")
  `KPC_ASSERT_SAME(a_repeat_long, clk, rst, m_tvalid, (repeat_mask & ~long_mask) == '0, "repeat without long")
  `KPC_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid, "result valid right after reset")
  `KPC_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled item changed")

endmodule

bind key_press_classifier kpc_checker #(.NUM_KEYS(NUM_KEYS)) u_kpc_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

### test/key_press_classifier_tb.sv
// Self-checking testbench for the key press classifier: directed table, random hold runs, checks.
`timescale 1ns / 100ps

module key_press_classifier_tb;
  import kpc_pkg::*;

  localparam int KEY_COUNT = 9;
  localparam int CNT_BITS = 16;
  localparam int REPEAT_TICKS = 500;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int STALL_AT = 300;
  localparam int STALL_CYCLES = 300;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [KEY_COUNT-1:0] rpt_m;
    logic [KEY_COUNT-1:0] once_m;
    logic [KEY_COUNT-1:0] long_m;
    logic [KEY_COUNT-1:0] held_m;
  } key_flags_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [REG_IDX_WIDTH-1:0] reg_idx;
    logic [THR_WIDTH-1:0] value;
    logic [KEY_COUNT-1:0] levels;
    logic checked;
    key_flags_t want;
  } row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [39:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  key_press_classifier #(
    .NUM_KEYS(KEY_COUNT),
    .COUNT_WIDTH(CNT_BITS),
    .REPEAT_PERIOD(REPEAT_TICKS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  logic [CNT_BITS-1:0] hold_cnt [KEY_COUNT];
  logic [THR_WIDTH-1:0] press_thr;
  logic [THR_WIDTH-1:0] long_thr;
  key_flags_t expected_flags [$];
  row_t plan [$];
  bit key_on [KEY_COUNT];
  int run_left [KEY_COUNT];
  string field_names [4] = '{"held", "long", "once", "repeat"};
  int fail_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int ticks_sent = 0;
  bit tx_calm = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic key_flags_t classify_tick(logic [KEY_COUNT-1:0] lv);
    key_flags_t f;
    logic adv;
    logic [CNT_BITS:0] c17;
    logic [CNT_BITS:0] p1;
    logic [CNT_BITS:0] l1;
    f = '0;
    p1 = {1'b0, press_thr} + 1'b1;
    l1 = {1'b0, long_thr} + 1'b1;
    for (int k = 0; k < KEY_COUNT; k++) begin
      adv = 1'b0;
      if (!lv[k]) begin
        hold_cnt[k] = '0;
      end else if (hold_cnt[k] != {CNT_BITS{1'b1}}) begin
        hold_cnt[k] = hold_cnt[k] + 1'b1;
        adv = 1'b1;
      end
      c17 = {1'b0, hold_cnt[k]};
      f.held_m[k] = hold_cnt[k] > press_thr;
      f.long_m[k] = hold_cnt[k] > long_thr;
      f.once_m[k] = adv && (c17 == p1);
      f.rpt_m[k] = adv && ((c17 == l1) ||
                           ((c17 > l1) && ((int'(hold_cnt[k]) % REPEAT_TICKS) == 0)));
    end
    return f;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic row_t mk_tick(logic [KEY_COUNT-1:0] lv, logic chk,
                                   logic [KEY_COUNT-1:0] h, logic [KEY_COUNT-1:0] l,
                                   logic [KEY_COUNT-1:0] o, logic [KEY_COUNT-1:0] r);
    row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.levels = lv;
    row.checked = chk;
    row.want.held_m = h;
    row.want.long_m = l;
    row.want.once_m = o;
    row.want.rpt_m = r;
    return row;
  endfunction

  function automatic row_t mk_cfg(logic [REG_IDX_WIDTH-1:0] idx, logic [THR_WIDTH-1:0] v);
    row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_idx = idx;
    row.value = v;
    return row;
  endfunction

  task automatic push_tick(logic [KEY_COUNT-1:0] lv, logic chk, key_flags_t want);
    int gap;
    key_flags_t f;
    if (ticks_sent % 128 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {{(16 - KEY_COUNT){1'b0}}, lv};
    do @(posedge clk); while (!s_tready);
    f = classify_tick(lv);
    expected_flags.push_back(chk ? want : f);
    ticks_sent++;
  endtask

  task automatic settle_outputs();
    @(negedge clk) s_tvalid <= 1'b0;
    while (expected_flags.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [THR_WIDTH-1:0] v);
    settle_outputs();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, v};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_PRESS) press_thr = v;
    else if (idx == REG_LONG) long_thr = v;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {16'h0000, v}) begin
      fail_count++;
      $display("%0t: register %0d read expected %h got %h", $time, idx, {16'h0000, v}, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Each key alternates between press runs and release runs; now and then a press run is
  // long enough to reach the long threshold and the repeat points.
  task automatic run_random(int n, int short_max, int long_lo, int long_hi, bit noise);
    logic [KEY_COUNT-1:0] lv;
    int anchor;
    anchor = $urandom_range(0, KEY_COUNT - 1);
    key_on[anchor] = 1'b1;
    run_left[anchor] = long_hi;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        if (run_left[k] == 0) begin
          key_on[k] = !key_on[k];
          if (key_on[k])
            run_left[k] = ($urandom_range(0, 11) == 0) ? $urandom_range(long_lo, long_hi)
                                                      : $urandom_range(1, short_max);
          else
            run_left[k] = $urandom_range(1, 8);
        end
        run_left[k]--;
        lv[k] = key_on[k];
      end
      if (noise && $urandom_range(0, 19) == 0) lv = lv ^ KEY_COUNT'($urandom);
      push_tick(lv, 1'b0, '0);
    end
  endtask

  initial begin : rx_side
    int hold_left;
    int stretch;
    bit calm;
    bit stall_done;
    hold_left = 0;
    stretch = 0;
    calm = 1'b0;
    stall_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      stretch++;
      if (stretch % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!stall_done && results_seen >= STALL_AT) begin
        stall_done = 1'b1;
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
        hold_left = pick_gap(calm);
      end
    end
  end

  always @(posedge clk) begin : check_results
    key_flags_t want;
    key_flags_t got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got = m_tdata[4*KEY_COUNT-1:0];
      if (expected_flags.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with none expected, expected none got %h", $time, m_tdata);
      end else begin
        want = expected_flags.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (got[f*KEY_COUNT +: KEY_COUNT] !== want[f*KEY_COUNT +: KEY_COUNT]) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: %s mask expected %h got %h", $time, field_names[f],
                       want[f*KEY_COUNT +: KEY_COUNT], got[f*KEY_COUNT +: KEY_COUNT]);
          end
        end
        if (m_tdata[39:4*KEY_COUNT] !== '0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: pad bits expected 0 got %h", $time, m_tdata[39:4*KEY_COUNT]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("key_press_classifier_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    press_thr = PRESS_RESET;
    long_thr = LONG_RESET;
    for (int k = 0; k < KEY_COUNT; k++) begin
      hold_cnt[k] = '0;
      key_on[k] = 1'b0;
      run_left[k] = 1;
    end

    plan.push_back(mk_tick(9'h1FF, 1'b1, 9'h000, 9'h000, 9'h000, 9'h000));
    plan.push_back(mk_tick(9'h000, 1'b1, 9'h000, 9'h000, 9'h000, 9'h000));
    plan.push_back(mk_cfg(REG_PRESS, 16'd0));
    plan.push_back(mk_cfg(REG_LONG, 16'd1));
    plan.push_back(mk_tick(9'h1FF, 1'b1, 9'h1FF, 9'h000, 9'h1FF, 9'h000));
    plan.push_back(mk_tick(9'h1FF, 1'b1, 9'h1FF, 9'h1FF, 9'h000, 9'h1FF));
    plan.push_back(mk_tick(9'h1FF, 1'b1, 9'h1FF, 9'h1FF, 9'h000, 9'h000));
    plan.push_back(mk_tick(9'h000, 1'b1, 9'h000, 9'h000, 9'h000, 9'h000));
    plan.push_back(mk_tick(9'h155, 1'b1, 9'h155, 9'h000, 9'h155, 9'h000));
    plan.push_back(mk_tick(9'h0AA, 1'b1, 9'h0AA, 9'h000, 9'h0AA, 9'h000));
    plan.push_back(mk_tick(9'h0AA, 1'b1, 9'h0AA, 9'h0AA, 9'h000, 9'h0AA));
    plan.push_back(mk_tick(9'h100, 1'b0, '0, '0, '0, '0));
    plan.push_back(mk_tick(9'h001, 1'b0, '0, '0, '0, '0));
    plan.push_back(mk_cfg(REG_PRESS, 16'd65534));
    plan.push_back(mk_cfg(REG_LONG, 16'd0));
    plan.push_back(mk_tick(9'h1FF, 1'b0, '0, '0, '0, '0));
    plan.push_back(mk_tick(9'h0FF, 1'b0, '0, '0, '0, '0));
    plan.push_back(mk_tick(9'h1FE, 1'b0, '0, '0, '0, '0));
    plan.push_back(mk_tick(9'h000, 1'b0, '0, '0, '0, '0));

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].reg_idx, plan[i].value);
      else push_tick(plan[i].levels, plan[i].checked, plan[i].want);
    end

    write_reg(REG_PRESS, 16'd5);
    write_reg(REG_LONG, 16'd20);
    run_random(500, 40, 400, 700, 1'b1);

    write_reg(REG_PRESS, PRESS_RESET);
    write_reg(REG_LONG, LONG_RESET);
    run_random(1000, 150, 1001, 1400, 1'b1);

    write_reg(REG_PRESS, 16'd1);
    write_reg(REG_LONG, 16'd3);
    run_random(350, 10, 5, 30, 1'b1);

    write_reg(REG_PRESS, 16'd0);
    write_reg(REG_LONG, 16'd0);
    run_random(100, 6, 8, 20, 1'b1);

    settle_outputs();
    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("key_press_classifier_tb: PASS");
    end else begin
      $display("key_press_classifier_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/kpc_pkg.sv
src/key_press_classifier.sv
src/kpc_checker.sv
test/key_press_classifier_tb.sv
